// ----- rtl/ppid_pkg.sv -----
// ppid_pkg: widths, feature constants, register indexes and the command/status
// structs shared by the positional pid regulator modules
// no dependencies
`default_nettype none

package ppid_pkg;

   // fixed point and feature constants
   localparam int FRAC_BITS     = 16;
   localparam int VAR_INT_START = 0;
   localparam int VAR_INT_END   = 0;
   localparam int DERIV_ALPHA   = 0;
   localparam int OUT_OFFSET    = 0;

   localparam bit VAR_ON   = (VAR_INT_END > VAR_INT_START);
   localparam bit ALPHA_ON = (DERIV_ALPHA > 0);

   // widths
   localparam int DATA_W     = 32;
   localparam int ERR_W      = 33;
   localparam int INT_W      = 48;
   localparam int FILT_W     = 34;
   localparam int ACC_W      = 96;
   localparam int Y_W        = 42;
   localparam int SCALE_BITS = 40;
   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int IDX_W      = 3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_KP           = 3'd0;
   localparam logic [IDX_W-1:0] REG_KI           = 3'd1;
   localparam logic [IDX_W-1:0] REG_KD           = 3'd2;
   localparam logic [IDX_W-1:0] REG_OUT_MAX      = 3'd3;
   localparam logic [IDX_W-1:0] REG_OUT_MIN      = 3'd4;
   localparam logic [IDX_W-1:0] REG_FEATURE_MODE = 3'd5;
   localparam logic [IDX_W-1:0] REG_SEP_BAND     = 3'd6;
   localparam logic [IDX_W-1:0] REG_DEAD_BAND    = 3'd7;

   // operations
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // divider operand selects
   localparam logic [1:0] DIV_VAR     = 2'd0;
   localparam logic [1:0] DIV_LIM_MAX = 2'd1;
   localparam logic [1:0] DIV_LIM_MIN = 2'd2;

   // product terms of the output sum
   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   typedef struct packed {
      logic       accept;
      logic       prep;
      logic       band;
      logic       vmul;
      logic       div_start;
      logic [1:0] div_sel;
      logic       var_take;
      logic       integ;
      logic       lim_max_take;
      logic       lim_min_take;
      logic       cap;
      logic       deriv;
      logic       filt_mul;
      logic       filt_add;
      logic       mac_step;
      logic [1:0] mac_term;
      logic [1:0] mac_chunk;
      logic       scale;
      logic       finish;
      logic       finish_clear;
   } ppid_cmd_type;

   typedef struct packed {
      logic op_clear;
      logic var_need;
      logic lim_need;
      logic div_done;
      logic out_full;
   } ppid_sts_type;

endpackage

`default_nettype wire

// ----- rtl/ppid_req_if.sv -----
// ppid_req_if: request channel carrying one update or clear word
// depends on ppid_pkg
`default_nettype none

interface ppid_req_if import ppid_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic signed [DATA_W-1:0] target;
   logic signed [DATA_W-1:0] actual;

   modport source (output valid, output operation, output target, output actual, input ready);
   modport sink   (input valid, input operation, input target, input actual, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppid_rsp_if.sv -----
// ppid_rsp_if: response channel carrying the drive word
// depends on ppid_pkg
`default_nettype none

interface ppid_rsp_if import ppid_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppid_csr_if.sv -----
// ppid_csr_if: register write channel, index plus data
// depends on ppid_pkg
`default_nettype none

interface ppid_csr_if import ppid_pkg::*;;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppid_div.sv -----
// ppid_div: iterative signed divider, one quotient bit per cycle, truncating
// depends on ppid_pkg
`default_nettype none

module ppid_div import ppid_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DIV_W-1:0]  num,
   input  wire logic signed [DATA_W-1:0] den,
   output logic                          done,
   output logic signed [DIV_W-1:0]       quo
);

   logic                 busy_ff, fix_ff, done_ff, neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DATA_W-1:0]    rem_ff, dmag_ff;
   logic [DIV_W-1:0]     q_ff;
   logic [DATA_W:0]      trial;
   logic                 fits;

   assign trial = {rem_ff, q_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, dmag_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            fix_ff  <= 1'b1;
         end else if (fix_ff) begin
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff    <= num[DIV_W-1] ? DIV_W'(-num) : num;
         dmag_ff <= den[DATA_W-1] ? DATA_W'(-den) : den;
         neg_ff  <= num[DIV_W-1] ^ den[DATA_W-1];
         rem_ff  <= '0;
         cnt_ff  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_ff) begin
         rem_ff <= fits ? DATA_W'(trial - {1'b0, dmag_ff}) : trial[DATA_W-1:0];
         q_ff   <= {q_ff[DIV_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end else if (fix_ff) begin
         q_ff <= neg_ff ? DIV_W'(-q_ff) : q_ff;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

`default_nettype wire

// ----- rtl/ppid_ctrl.sv -----
// ppid_ctrl: sequencing state machine for the regulator update and clear
// depends on ppid_pkg
`default_nettype none

module ppid_ctrl import ppid_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   input  ppid_sts_type sts,
   output ppid_cmd_type cmd
);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_PREP    = 5'd1;
   localparam logic [4:0] ST_BAND    = 5'd2;
   localparam logic [4:0] ST_VMUL    = 5'd3;
   localparam logic [4:0] ST_VSTART  = 5'd4;
   localparam logic [4:0] ST_VWAIT   = 5'd5;
   localparam logic [4:0] ST_INTEG   = 5'd6;
   localparam logic [4:0] ST_L1START = 5'd7;
   localparam logic [4:0] ST_L1WAIT  = 5'd8;
   localparam logic [4:0] ST_L2START = 5'd9;
   localparam logic [4:0] ST_L2WAIT  = 5'd10;
   localparam logic [4:0] ST_CAP     = 5'd11;
   localparam logic [4:0] ST_DERIV   = 5'd12;
   localparam logic [4:0] ST_FILT1   = 5'd13;
   localparam logic [4:0] ST_FILT2   = 5'd14;
   localparam logic [4:0] ST_MAC     = 5'd15;
   localparam logic [4:0] ST_SCALE   = 5'd16;
   localparam logic [4:0] ST_OUT     = 5'd17;
   localparam logic [4:0] ST_CLEAR   = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [1:0] term_ff, term_in, chunk_ff, chunk_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      term_in  = term_ff;
      chunk_in = chunk_ff;
      cmd.mac_term  = term_ff;
      cmd.mac_chunk = chunk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PREP;
            end
         end
         ST_PREP: begin
            if (sts.op_clear) begin
               state_in = ST_CLEAR;
            end else begin
               cmd.prep = 1'b1;
               state_in = ST_BAND;
            end
         end
         ST_BAND: begin
            cmd.band = 1'b1;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            if (sts.var_need) begin
               state_in = ST_VMUL;
            end else begin
               cmd.integ = 1'b1;
               state_in  = ST_L1START;
            end
         end
         ST_VMUL: begin
            cmd.vmul = 1'b1;
            state_in = ST_VSTART;
         end
         ST_VSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_VAR;
            state_in      = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (sts.div_done) begin
               cmd.var_take = 1'b1;
               state_in     = ST_INTEG;
            end
         end
         ST_L1START: begin
            if (sts.lim_need) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_LIM_MAX;
               state_in      = ST_L1WAIT;
            end else begin
               state_in = ST_DERIV;
            end
         end
         ST_L1WAIT: begin
            if (sts.div_done) begin
               cmd.lim_max_take = 1'b1;
               state_in         = ST_L2START;
            end
         end
         ST_L2START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LIM_MIN;
            state_in      = ST_L2WAIT;
         end
         ST_L2WAIT: begin
            if (sts.div_done) begin
               cmd.lim_min_take = 1'b1;
               state_in         = ST_CAP;
            end
         end
         ST_CAP: begin
            cmd.cap  = 1'b1;
            state_in = ST_DERIV;
         end
         ST_DERIV: begin
            cmd.deriv = 1'b1;
            state_in  = ALPHA_ON ? ST_FILT1 : ST_MAC;
         end
         ST_FILT1: begin
            cmd.filt_mul = 1'b1;
            state_in     = ST_FILT2;
         end
         ST_FILT2: begin
            cmd.filt_add = 1'b1;
            state_in     = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_step = 1'b1;
            if (chunk_ff == 2'd2) begin
               chunk_in = 2'd0;
               if (term_ff == TERM_D) begin
                  term_in  = TERM_P;
                  state_in = ST_SCALE;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end else begin
               chunk_in = chunk_ff + 2'd1;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (!sts.out_full) begin
               cmd.finish_clear = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_P;
         chunk_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         chunk_ff <= chunk_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_mac_counters_rest: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_MAC |-> (term_ff == TERM_P && chunk_ff == 2'd0))
      else $error("mac counters not at rest outside mac");

   a_finish_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.finish_clear) |-> !sts.out_full)
      else $error("result written over a pending word");

   a_accept_goes_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_PREP)
      else $error("accepted word not sequenced");

   a_div_start_from_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_VWAIT || state_ff == ST_L1WAIT
                         || state_ff == ST_L2WAIT))
      else $error("divider started outside a wait sequence");
`endif

endmodule

`default_nettype wire

// ----- rtl/ppid_dpath.sv -----
// ppid_dpath: registers, history and arithmetic of the regulator
// depends on ppid_pkg and ppid_div
`default_nettype none

module ppid_dpath import ppid_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  ppid_cmd_type                  cmd,
   output ppid_sts_type                  sts,
   input  wire logic                     req_operation,
   input  wire logic signed [DATA_W-1:0] req_target,
   input  wire logic signed [DATA_W-1:0] req_actual,
   input  wire logic                     csr_write,
   input  wire logic [IDX_W-1:0]         csr_index,
   input  wire logic [DATA_W-1:0]        csr_data,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_drive
);

   localparam logic [ERR_W-1:0]        VAR_START_W = ERR_W'(VAR_INT_START);
   localparam logic [ERR_W-1:0]        VAR_END_W   = ERR_W'(VAR_INT_END);
   localparam logic signed [DATA_W-1:0] VAR_SPAN   = DATA_W'(VAR_INT_END - VAR_INT_START);
   localparam logic signed [17:0]      ALPHA_S     = 18'(DERIV_ALPHA);
   localparam logic signed [ACC_W-1:0] SCALE_MAX   = ACC_W'(1) <<< SCALE_BITS;
   localparam logic signed [ACC_W-1:0] SCALE_MIN   = -SCALE_MAX;
   localparam logic signed [Y_W-1:0]   OFFSET_Y    = Y_W'(OUT_OFFSET);

   function automatic logic signed [INT_W-1:0] sat_int(input logic signed [DIV_W-1:0] v);
      logic signed [DIV_W-1:0] hi, lo;
      hi = (DIV_W'(1) <<< (INT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi)      return hi[INT_W-1:0];
      else if (v < lo) return lo[INT_W-1:0];
      else             return v[INT_W-1:0];
   endfunction

   function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [DIV_W-1:0] v);
      logic signed [DIV_W-1:0] hi, lo;
      hi = (DIV_W'(1) <<< (FILT_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi)      return hi[FILT_W-1:0];
      else if (v < lo) return lo[FILT_W-1:0];
      else             return v[FILT_W-1:0];
   endfunction

   // configuration
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff, out_max_ff, out_min_ff;
   logic [1:0]               mode_ff;
   logic [30:0]              sep_ff, dead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         out_max_ff <= 32'sh7FFF_FFFF;
         out_min_ff <= 32'sh8000_0000;
         mode_ff    <= 2'd1;
         sep_ff     <= '0;
         dead_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_KP:           kp_ff      <= csr_data;
            REG_KI:           ki_ff      <= csr_data;
            REG_KD:           kd_ff      <= csr_data;
            REG_OUT_MAX:      out_max_ff <= csr_data;
            REG_OUT_MIN:      out_min_ff <= csr_data;
            REG_FEATURE_MODE: mode_ff    <= csr_data[1:0];
            REG_SEP_BAND:     sep_ff     <= csr_data[30:0];
            REG_DEAD_BAND:    dead_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // working registers
   logic                      op_ff, var_need_ff;
   logic signed [DATA_W-1:0]  target_ff, actual_ff, kieff_ff;
   logic signed [ERR_W-1:0]   e_raw_ff, e_ff, dprev_ff;
   logic [ERR_W-1:0]          ae_ff;
   logic signed [DIV_W-1:0]   vprod_ff;
   logic signed [INT_W-1:0]   lim_a_ff, lim_b_ff;
   logic signed [FILT_W-1:0]  d_ff;
   logic signed [52:0]        fprod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [Y_W-1:0]     y_ff;

   // history
   logic signed [ERR_W-1:0]   prev_err_ff;
   logic signed [INT_W-1:0]   integ_ff;
   logic signed [DATA_W-1:0]  prev_act_ff;
   logic signed [FILT_W-1:0]  filt_ff;

   // output register
   logic                      rsp_valid_ff;
   logic signed [DATA_W-1:0]  drive_ff;

   // deadband, separation and variable band
   logic [ERR_W-1:0]         ae_raw, ae_fin;
   logic                     dead, freeze, var_kill, var_need_n;
   logic signed [DATA_W-1:0] kb;

   always_comb begin
      ae_raw     = e_raw_ff[ERR_W-1] ? ERR_W'(-e_raw_ff) : e_raw_ff;
      dead       = (dead_ff != '0) && (ae_raw <= {2'b00, dead_ff});
      ae_fin     = dead ? '0 : ae_raw;
      freeze     = (sep_ff != '0) && (ae_fin > {2'b00, sep_ff});
      kb         = freeze ? '0 : ki_ff;
      var_kill   = VAR_ON && (kb != '0) && (ae_fin >= VAR_END_W);
      var_need_n = VAR_ON && (kb != '0) && (ae_fin > VAR_START_W) && !var_kill;
   end

   // variable band product
   logic [ERR_W-1:0]         vspan;
   logic signed [DATA_W-1:0] vspan_s;
   logic signed [DIV_W-1:0]  vprod_n;

   assign vspan   = VAR_END_W - ae_ff;
   assign vspan_s = $signed({1'b0, vspan[30:0]});
   assign vprod_n = ki_ff * vspan_s;

   // divider
   logic                     div_done;
   logic signed [DIV_W-1:0]  div_q, div_num;
   logic signed [DATA_W-1:0] div_den;

   always_comb begin
      case (cmd.div_sel)
         DIV_VAR: begin
            div_num = vprod_n;
            div_num = vprod_ff;
            div_den = VAR_SPAN;
         end
         DIV_LIM_MAX: begin
            div_num = DIV_W'(out_max_ff) <<< FRAC_BITS;
            div_den = ki_ff;
         end
         default: begin
            div_num = DIV_W'(out_min_ff) <<< FRAC_BITS;
            div_den = ki_ff;
         end
      endcase
   end

   ppid_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   // integral and cap
   logic signed [INT_W-1:0] top, bot, cap1;
   assign top  = ki_ff[DATA_W-1] ? lim_b_ff : lim_a_ff;
   assign bot  = ki_ff[DATA_W-1] ? lim_a_ff : lim_b_ff;
   assign cap1 = (integ_ff > top) ? top : integ_ff;

   // derivative and low-pass
   logic signed [FILT_W-1:0] d_n;
   logic signed [FILT_W:0]   fdiff;
   logic signed [DIV_W-1:0]  fsum;
   logic signed [FILT_W-1:0] filt_n;

   assign d_n    = mode_ff[1] ? (FILT_W'(actual_ff) - FILT_W'(prev_act_ff))
                              : (FILT_W'(e_ff) - FILT_W'(dprev_ff));
   assign fdiff  = (FILT_W+1)'(d_ff) - (FILT_W+1)'(filt_ff);
   assign fsum   = DIV_W'(filt_ff) + DIV_W'(fprod_ff >>> 16);
   assign filt_n = sat_filt(fsum);

   // multiply-accumulate, one 16-bit chunk of the second operand per cycle
   logic signed [DATA_W-1:0] mac_a;
   logic signed [INT_W-1:0]  mac_b;
   logic signed [16:0]       mac_c;
   logic signed [48:0]       mac_p;
   logic signed [ACC_W-1:0]  mac_ext, mac_sh;

   always_comb begin
      case (cmd.mac_term)
         TERM_P: begin
            mac_a = kp_ff;
            mac_b = INT_W'(e_ff);
         end
         TERM_I: begin
            mac_a = kieff_ff;
            mac_b = integ_ff;
         end
         default: begin
            mac_a = kd_ff;
            mac_b = INT_W'(d_ff);
         end
      endcase
      case (cmd.mac_chunk)
         2'd0:    mac_c = $signed({1'b0, mac_b[15:0]});
         2'd1:    mac_c = $signed({1'b0, mac_b[31:16]});
         default: mac_c = $signed({mac_b[47], mac_b[47:32]});
      endcase
      mac_p   = mac_a * mac_c;
      mac_ext = ACC_W'(mac_p);
      case (cmd.mac_chunk)
         2'd0:    mac_sh = mac_ext;
         2'd1:    mac_sh = mac_ext <<< 16;
         default: mac_sh = mac_ext <<< 32;
      endcase
   end

   // scale, offset and clamp
   logic signed [ACC_W-1:0] shifted;
   logic signed [Y_W-1:0]   ysat, yc1, yc2;

   assign shifted = acc_ff >>> FRAC_BITS;
   assign ysat    = (shifted > SCALE_MAX) ? Y_W'(SCALE_MAX)
                  : (shifted < SCALE_MIN) ? Y_W'(SCALE_MIN) : Y_W'(shifted);
   assign yc1     = (y_ff > Y_W'(out_max_ff)) ? Y_W'(out_max_ff) : y_ff;
   assign yc2     = (yc1 < Y_W'(out_min_ff)) ? Y_W'(out_min_ff) : yc1;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         target_ff <= req_target;
         actual_ff <= req_actual;
      end
      if (cmd.prep) begin
         e_raw_ff <= ERR_W'(target_ff) - ERR_W'(actual_ff);
      end
      if (cmd.band) begin
         e_ff        <= dead ? '0 : e_raw_ff;
         dprev_ff    <= dead ? '0 : prev_err_ff;
         ae_ff       <= ae_fin;
         kieff_ff    <= var_kill ? '0 : kb;
         var_need_ff <= var_need_n;
      end
      if (cmd.vmul) begin
         vprod_ff <= vprod_n;
      end
      if (cmd.var_take) begin
         kieff_ff    <= div_q[DATA_W-1:0];
         var_need_ff <= 1'b0;
      end
      if (cmd.lim_max_take) begin
         lim_a_ff <= sat_int(div_q);
      end
      if (cmd.lim_min_take) begin
         lim_b_ff <= sat_int(div_q);
      end
      if (cmd.deriv) begin
         d_ff   <= d_n;
         acc_ff <= '0;
      end
      if (cmd.filt_mul) begin
         fprod_ff <= ALPHA_S * fdiff;
      end
      if (cmd.filt_add) begin
         d_ff <= filt_n;
      end
      if (cmd.mac_step) begin
         acc_ff <= acc_ff + mac_sh;
      end
      if (cmd.scale) begin
         y_ff <= ysat + OFFSET_Y;
      end
   end

   // history
   always_ff @(posedge clock) begin
      if (reset || cmd.finish_clear) begin
         prev_err_ff <= '0;
         integ_ff    <= '0;
         prev_act_ff <= '0;
         filt_ff     <= '0;
      end else begin
         if (cmd.band && dead && mode_ff[1]) begin
            prev_act_ff <= actual_ff;
         end
         if (cmd.integ) begin
            if (kieff_ff != '0) begin
               integ_ff <= sat_int(DIV_W'(integ_ff) + DIV_W'(e_ff));
            end else if (ki_ff == '0) begin
               integ_ff <= '0;
            end
         end
         if (cmd.cap) begin
            integ_ff <= (cap1 < bot) ? bot : cap1;
         end
         if (cmd.filt_add) begin
            filt_ff <= filt_n;
         end
         if (cmd.finish) begin
            prev_err_ff <= e_ff;
            if (mode_ff[1]) begin
               prev_act_ff <= actual_ff;
            end
         end
      end
   end

   // result register, refilled in the cycle the old word leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish || cmd.finish_clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         drive_ff <= yc2[DATA_W-1:0];
      end else if (cmd.finish_clear) begin
         drive_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = drive_ff;

   assign sts.op_clear = (op_ff == OP_CLEAR);
   assign sts.var_need = var_need_ff;
   assign sts.lim_need = mode_ff[0] && (ki_ff != '0) && (kieff_ff != '0);
   assign sts.div_done = div_done;
   assign sts.out_full = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

// ----- rtl/positional_pid_regulator.sv -----
// positional_pid_regulator: top level, joins the sequencer and the datapath
// depends on ppid_pkg, the ppid channel interfaces, ppid_ctrl and ppid_dpath
`default_nettype none

// Positional PID regulator in signed Q16.16. Each request word carries an
// operation, a target and an actual value; each one yields exactly one
// response word with the clamped drive (0 for a clear). Words are handled one
// at a time: an update runs through input capture, error, band checks,
// integral, derivative, a shared 32x17 multiply-accumulate over three 16-bit
// chunks of each of the P, I and D terms, and scaling. When the integral
// limit is enabled and the integral moves, two divisions by ki run on the
// shared one-bit-per-cycle divider; the variable-integral band, when
// configured, adds one more division. A clear skips the arithmetic. The
// result sits in an output register, so the next request word is taken
// while the last drive word still waits. Registers are to be written over
// the csr channel only while the regulator is idle; the block itself leaves
// this to the user. The csr channel is always ready.

module positional_pid_regulator import ppid_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ppid_req_if.sink   req_bus,
   ppid_rsp_if.source rsp_bus,
   ppid_csr_if.sink   csr_bus
);

   ppid_cmd_type cmd;
   ppid_sts_type sts;
   logic         req_ready;
   logic         rsp_valid;
   logic signed [DATA_W-1:0] rsp_drive;

   // register writes never stall
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
   assign rsp_bus.drive = rsp_drive;

   // sequencer
   ppid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, history and configuration
   ppid_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_bus.operation),
      .req_target    (req_bus.target),
      .req_actual    (req_bus.actual),
      .csr_write     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_valid),
      .rsp_drive     (rsp_drive)
   );

endmodule

`default_nettype wire
